// ===== hw/rtl/lpcd_pkg.sv =====
// Shared types and codes for the length-prefixed channel deframer.
// Holds the classified byte word, phase, error, kind and status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lpcd_pkg;

    // Classified stream byte handed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       is_nul;
        logic       is_digit;
        logic [3:0] digit;
    } class_t;

    // Parse phases
    localparam logic [1:0] PH_LENGTH  = 2'd0;
    localparam logic [1:0] PH_CHANNEL = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;

    // Sticky error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_SIZE    = 2'd1;
    localparam logic [1:0] ERR_DIGIT   = 2'd2;
    localparam logic [1:0] ERR_CHANNEL = 2'd3;

    // Output kinds
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_CHANNEL = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;

    // Status codes
    localparam logic [2:0] ST_LENGTH    = 3'd0;
    localparam logic [2:0] ST_PAYLOAD   = 3'd2;
    localparam logic [2:0] ST_ERR_BASE  = 3'd2;
    localparam logic [2:0] ST_ERR_FIRST = 3'd3;

    // Digit counting
    localparam logic [2:0] DIGIT_SAT  = 3'd7;
    localparam logic [2:0] DIGIT_CAP  = 3'd6;

    // ASCII
    localparam logic [7:0] CHAR_NUL  = 8'h00;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    // Register map
    localparam logic REG_MAX_DIGITS = 1'b0;
    localparam logic REG_MAX_HEADER = 1'b1;

    localparam logic [2:0] MAX_DIGITS_RESET = 3'd6;
    localparam logic [9:0] MAX_HEADER_RESET = 10'd512;

endpackage

`default_nettype wire

// ===== hw/rtl/lpcd_front.sv =====
// Front end of the deframer: accepts stream bytes, classifies them and
// queues them in a two-entry queue for the back end.
// Depends on lpcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpcd_front
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  wire  [7:0]           in_byte,
    output logic                 q_valid,
    output lpcd_pkg::class_t     q_item,
    input  wire                  q_pop
);

    lpcd_pkg::class_t entry_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             push;
    logic             pop;
    lpcd_pkg::class_t cls;

    always_comb
    begin
        cls.data     = in_byte;
        cls.is_nul   = (in_byte == lpcd_pkg::CHAR_NUL);
        cls.is_digit = (in_byte >= lpcd_pkg::CHAR_ZERO) && (in_byte <= lpcd_pkg::CHAR_NINE);
        cls.digit    = in_byte[3:0];
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lpcd_back.sv =====
// Back end of the deframer: runs the frame parser on classified words and
// holds the result in an output register.
// Depends on lpcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpcd_back
#(
    parameter int LENGTH_WIDTH       = 20,
    parameter int HEADER_INDEX_WIDTH = 11
)
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      q_valid,
    input  wire  lpcd_pkg::class_t   q_item,
    output logic                     q_pop,
    input  wire  [2:0]               max_length_digits,
    input  wire  [9:0]               max_header_index,
    output logic                     out_valid,
    input  wire                      out_ready,
    output logic [1:0]               out_kind,
    output logic [7:0]               out_byte,
    output logic                     frame_done,
    output logic                     header_done,
    output logic [LENGTH_WIDTH-1:0]  frame_length,
    output logic [2:0]               status
);

    localparam int CMP_WIDTH = (HEADER_INDEX_WIDTH > 10) ? HEADER_INDEX_WIDTH : 10;

    logic [1:0]                    phase_reg;
    logic [1:0]                    phase_next;
    logic [1:0]                    error_reg;
    logic [1:0]                    error_next;
    logic [2:0]                    digit_count_reg;
    logic [2:0]                    digit_count_next;
    logic                          bad_digit_reg;
    logic                          bad_digit_next;
    logic [LENGTH_WIDTH-1:0]       length_reg;
    logic [LENGTH_WIDTH-1:0]       length_next;
    logic [HEADER_INDEX_WIDTH-1:0] header_pos_reg;
    logic [HEADER_INDEX_WIDTH-1:0] header_pos_next;
    logic [HEADER_INDEX_WIDTH-1:0] header_pos_bump;
    logic [LENGTH_WIDTH-1:0]       remaining_reg;
    logic [LENGTH_WIDTH-1:0]       remaining_next;
    logic [LENGTH_WIDTH-1:0]       remaining_dec;
    logic [LENGTH_WIDTH+3:0]       length_times10;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [1:0]                    kind_reg;
    logic [1:0]                    kind_next;
    logic [7:0]                    byte_reg;
    logic [7:0]                    byte_next;
    logic                          fdone_reg;
    logic                          fdone_next;
    logic                          hdone_reg;
    logic                          hdone_next;
    logic [LENGTH_WIDTH-1:0]       flen_reg;
    logic [LENGTH_WIDTH-1:0]       flen_next;
    logic [2:0]                    status_reg;
    logic [2:0]                    status_next;
    logic                          clear_frame;

    assign q_pop = q_valid && (!out_valid_reg || out_ready);

    assign header_pos_bump = (header_pos_reg != {HEADER_INDEX_WIDTH{1'b1}}) ?
                             header_pos_reg + HEADER_INDEX_WIDTH'(1) : header_pos_reg;
    assign length_times10  = {1'b0, length_reg, 3'b000} + {3'b000, length_reg, 1'b0}
                             + (LENGTH_WIDTH+4)'(q_item.digit);
    assign remaining_dec   = remaining_reg - LENGTH_WIDTH'(1);

    always_comb
    begin
        phase_next       = phase_reg;
        error_next       = error_reg;
        digit_count_next = digit_count_reg;
        bad_digit_next   = bad_digit_reg;
        length_next      = length_reg;
        header_pos_next  = header_pos_reg;
        remaining_next   = remaining_reg;
        kind_next        = lpcd_pkg::KIND_NONE;
        byte_next        = 8'd0;
        fdone_next       = 1'b0;
        hdone_next       = 1'b0;
        flen_next        = '0;
        clear_frame      = 1'b0;

        if (error_reg == lpcd_pkg::ERR_NONE)
        begin
            unique case (phase_reg)
                lpcd_pkg::PH_LENGTH:
                begin
                    if (q_item.is_nul)
                    begin
                        if (digit_count_reg == lpcd_pkg::DIGIT_SAT
                            || digit_count_reg > max_length_digits)
                        begin
                            error_next = lpcd_pkg::ERR_SIZE;
                        end
                        else if (bad_digit_reg || digit_count_reg == 3'd0)
                        begin
                            error_next = lpcd_pkg::ERR_DIGIT;
                        end
                        else
                        begin
                            phase_next = lpcd_pkg::PH_CHANNEL;
                        end
                    end
                    else
                    begin
                        if (!q_item.is_digit)
                        begin
                            bad_digit_next = 1'b1;
                        end
                        else if (digit_count_reg < lpcd_pkg::DIGIT_CAP)
                        begin
                            length_next = length_times10[LENGTH_WIDTH-1:0];
                        end
                        if (digit_count_reg != lpcd_pkg::DIGIT_SAT)
                        begin
                            digit_count_next = digit_count_reg + 3'd1;
                        end
                    end
                    if (error_next == lpcd_pkg::ERR_NONE)
                    begin
                        header_pos_next = header_pos_bump;
                    end
                end
                lpcd_pkg::PH_CHANNEL:
                begin
                    if (q_item.is_nul)
                    begin
                        if (CMP_WIDTH'(header_pos_reg) > CMP_WIDTH'(max_header_index))
                        begin
                            error_next = lpcd_pkg::ERR_CHANNEL;
                        end
                        else
                        begin
                            hdone_next = 1'b1;
                            flen_next  = length_reg;
                            if (length_reg == '0)
                            begin
                                fdone_next  = 1'b1;
                                clear_frame = 1'b1;
                            end
                            else
                            begin
                                remaining_next = length_reg;
                                phase_next     = lpcd_pkg::PH_PAYLOAD;
                            end
                        end
                    end
                    else
                    begin
                        kind_next       = lpcd_pkg::KIND_CHANNEL;
                        byte_next       = q_item.data;
                        header_pos_next = header_pos_bump;
                    end
                end
                default:
                begin
                    kind_next      = lpcd_pkg::KIND_PAYLOAD;
                    byte_next      = q_item.data;
                    remaining_next = remaining_dec;
                    if (remaining_dec == '0)
                    begin
                        fdone_next  = 1'b1;
                        clear_frame = 1'b1;
                    end
                end
            endcase
        end

        if (clear_frame)
        begin
            phase_next       = lpcd_pkg::PH_LENGTH;
            digit_count_next = 3'd0;
            bad_digit_next   = 1'b0;
            length_next      = '0;
            header_pos_next  = '0;
            remaining_next   = '0;
        end

        status_next = (error_next != lpcd_pkg::ERR_NONE) ?
                      {1'b0, error_next} + lpcd_pkg::ST_ERR_BASE : {1'b0, phase_next};
        out_valid_next = q_pop ? 1'b1 : (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= lpcd_pkg::PH_LENGTH;
            error_reg       <= lpcd_pkg::ERR_NONE;
            digit_count_reg <= 3'd0;
            bad_digit_reg   <= 1'b0;
            length_reg      <= '0;
            header_pos_reg  <= '0;
            remaining_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                phase_reg       <= phase_next;
                error_reg       <= error_next;
                digit_count_reg <= digit_count_next;
                bad_digit_reg   <= bad_digit_next;
                length_reg      <= length_next;
                header_pos_reg  <= header_pos_next;
                remaining_reg   <= remaining_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            kind_reg   <= kind_next;
            byte_reg   <= byte_next;
            fdone_reg  <= fdone_next;
            hdone_reg  <= hdone_next;
            flen_reg   <= flen_next;
            status_reg <= status_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_kind     = kind_reg;
    assign out_byte     = byte_reg;
    assign frame_done   = fdone_reg;
    assign header_done  = hdone_reg;
    assign frame_length = flen_reg;
    assign status       = status_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/length_prefixed_channel_deframer.sv =====
// A word accepted at the input passes through a front queue entry, then the back-end output register.
// Throughput: one word per cycle while the output is not stalled, limited by the single parser step in the back end.
// A two-entry queue between front and back and the output register let each side stall.
// Reset: rst_n clears all parse state and errors, max_length_digits to 6,
// max_header_index to 512. No clearing pass; words are accepted right after reset.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_channel_deframer
#(
    parameter int LENGTH_WIDTH       = 20,
    parameter int HEADER_INDEX_WIDTH = 11
)
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      psel,
    input  wire                      penable,
    input  wire                      pwrite,
    input  wire  [2:0]               paddr,
    input  wire  [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  wire                      in_valid,
    output logic                     in_ready,
    input  wire  [7:0]               in_byte,
    output logic                     out_valid,
    input  wire                      out_ready,
    output logic [1:0]               out_kind,
    output logic [7:0]               out_byte,
    output logic                     frame_done,
    output logic                     header_done,
    output logic [LENGTH_WIDTH-1:0]  frame_length,
    output logic [2:0]               status
);

    logic [2:0]       max_digits_reg;
    logic [9:0]       max_header_reg;
    logic             cfg_write;
    logic             q_valid;
    logic             q_pop;
    lpcd_pkg::class_t q_item;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_digits_reg <= lpcd_pkg::MAX_DIGITS_RESET;
            max_header_reg <= lpcd_pkg::MAX_HEADER_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                lpcd_pkg::REG_MAX_DIGITS: max_digits_reg <= pwdata[2:0];
                lpcd_pkg::REG_MAX_HEADER: max_header_reg <= pwdata[9:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            lpcd_pkg::REG_MAX_DIGITS: prdata = {29'd0, max_digits_reg};
            lpcd_pkg::REG_MAX_HEADER: prdata = {22'd0, max_header_reg};
        endcase
    end

    lpcd_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_byte  (in_byte),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    lpcd_back
    #(
        .LENGTH_WIDTH       (LENGTH_WIDTH),
        .HEADER_INDEX_WIDTH (HEADER_INDEX_WIDTH)
    )
    u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_valid           (q_valid),
        .q_item            (q_item),
        .q_pop             (q_pop),
        .max_length_digits (max_digits_reg),
        .max_header_index  (max_header_reg),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .out_kind          (out_kind),
        .out_byte          (out_byte),
        .frame_done        (frame_done),
        .header_done       (header_done),
        .frame_length      (frame_length),
        .status            (status)
    );

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> (out_kind == lpcd_pkg::KIND_PAYLOAD || header_done))
        else $error("frame end on a word that is neither payload nor header end");

    a_header_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && header_done |->
            (status == lpcd_pkg::ST_PAYLOAD || status == lpcd_pkg::ST_LENGTH))
        else $error("header end with unexpected status");

    a_error_silent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status >= lpcd_pkg::ST_ERR_FIRST |->
            (out_kind == lpcd_pkg::KIND_NONE && !header_done && !frame_done))
        else $error("word passed on under error status");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && status >= lpcd_pkg::ST_ERR_FIRST ##1 out_valid |->
            status == $past(status))
        else $error("error status changed");

endmodule

`default_nettype wire
